// File: sv/binary_morph_3x3_neighbour_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for binary_morph_3x3_neighbour
// Concurrent checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPH_3X3_NEIGHBOUR_MACROS_SVH
`define BINARY_MORPH_3X3_NEIGHBOUR_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BM3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bm3 check failed");

// antecedent implies consequent in the next cycle
`define BM3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bm3 check failed");

`else

`define BM3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BM3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared constants and types of the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 13;
    localparam int MASK_W  = 8;
    localparam int COL_H   = 3;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 13;

    localparam logic [PIX_W-1:0] PIX_ON = 8'hFF;

    localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MASK   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_IMG_W  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_IMG_H  = 2'd3;

    localparam logic [MASK_W-1:0]  RST_MASK  = 8'hFF;
    localparam logic [IMG_W_W-1:0] RST_IMG_W = 11'd1024;
    localparam logic [IMG_H_W-1:0] RST_IMG_H = 13'd1024;

    // per-word control handed from the position tracker to the window stage
    typedef struct packed {
        logic take;
        logic set_bit;
        logic emit;
        logic last;
        logic colv0;
        logic colv2;
        logic rowv0;
        logic rowv2;
    } t_item;

endpackage

// File: sv/bm3_in_if.sv
// ----------------------------------------------------------------------------
// bm3_in_if
// Input pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bm3_in_if import bm3_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             is_padding;

    modport source (output valid, output pixel_in, output is_padding, input ready);
    modport sink   (input valid, input pixel_in, input is_padding, output ready);
endinterface

// File: sv/bm3_out_if.sv
// ----------------------------------------------------------------------------
// bm3_out_if
// Result pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bm3_out_if import bm3_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// File: sv/bm3_cell.sv
// ----------------------------------------------------------------------------
// bm3_cell
// One window column: holds three bits, shifts in from its neighbor and
// checks its selected bits against the mode.
// ----------------------------------------------------------------------------
module bm3_cell import bm3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_clear,
    input  logic [COL_H-1:0] i_col,
    input  logic [COL_H-1:0] i_sel,
    input  logic             i_mode,
    output logic [COL_H-1:0] o_col,
    output logic             o_hit
);

    logic [COL_H-1:0] r_col;
    logic [COL_H-1:0] n_col;

    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_clear ? '0 : i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    // judged on the incoming column, which is the window after the shift
    assign o_hit = |(i_sel & (i_col ^ {COL_H{i_mode}}));
    assign o_col = r_col;

endmodule

// File: sv/bm3_line.sv
// ----------------------------------------------------------------------------
// bm3_line
// Line store: two bits per column, registered read with write forwarding.
// ----------------------------------------------------------------------------
module bm3_line import bm3_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [1:0]               i_wr_data,
    output logic [1:0]               o_rd_data
);

    logic [1:0] r_mem [0:DEPTH-1];
    logic [1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: sv/bm3_pos.sv
// ----------------------------------------------------------------------------
// bm3_pos
// Stream position and frame size tracking; derives per-word window control.
// ----------------------------------------------------------------------------
`include "binary_morph_3x3_neighbour_macros.svh"

module bm3_pos import bm3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [PIX_W-1:0]             i_pixel,
    input  logic                         i_pad,
    input  logic [IMG_W_W-1:0]           i_img_w,
    input  logic [IMG_H_W-1:0]           i_img_h,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output t_item                        o_item
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int FWW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int FHW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [FWW-1:0] r_fw, n_fw;
    logic [FHW-1:0] r_fh, n_fh;

    logic [FWW-1:0] fw_live, fw;
    logic [FHW-1:0] fh_live, fh;
    logic [CW-1:0]  cx;
    logic [RW-1:0]  cy;
    logic           first, drain, ignore, emit, c0, last, wrap;

    always_comb begin
        if (i_img_w == '0) begin
            fw_live = FWW'(1);
        end else if (32'(i_img_w) > MAX_WIDTH) begin
            fw_live = FWW'(MAX_WIDTH);
        end else begin
            fw_live = FWW'(i_img_w);
        end
        if (i_img_h == '0) begin
            fh_live = FHW'(1);
        end else if (32'(i_img_h) > MAX_HEIGHT) begin
            fh_live = FHW'(MAX_HEIGHT);
        end else begin
            fh_live = FHW'(i_img_h);
        end
    end

    always_comb begin
        first  = (r_col == '0) && (r_row == '0);
        fw     = first ? fw_live : r_fw;
        fh     = first ? fh_live : r_fh;
        drain  = r_row >= RW'(fh);
        ignore = !drain && i_pad;
        c0     = r_col == '0;
        emit   = (r_row >= RW'(2)) || ((r_row == RW'(1)) && !c0);

        if (c0) begin
            cx = CW'(fw - FWW'(1));
            cy = (r_row >= RW'(2)) ? r_row - RW'(2) : '0;
        end else begin
            cx = r_col - CW'(1);
            cy = (r_row != '0) ? r_row - RW'(1) : '0;
        end

        last = emit && (FWW'(cx) == fw - FWW'(1)) && (cy == RW'(fh) - RW'(1));
        wrap = (FWW'(r_col) + FWW'(1)) >= fw;

        o_item.take    = !ignore;
        o_item.set_bit = !drain && (i_pixel != '0);
        o_item.emit    = emit;
        o_item.last    = last;
        o_item.colv0   = cx != '0;
        o_item.colv2   = (FWW'(cx) + FWW'(1)) < fw;
        o_item.rowv0   = cy != '0;
        o_item.rowv2   = (cy + RW'(1)) < RW'(fh);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_fw  = r_fw;
        n_fh  = r_fh;
        if (i_accept) begin
            if (first) begin
                n_fw = fw_live;
                n_fh = fh_live;
            end
            if (!ignore) begin
                if (last) begin
                    n_col = '0;
                    n_row = '0;
                end else if (wrap) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_fw  <= FWW'(1);
            r_fh  <= FHW'(1);
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fw  <= n_fw;
            r_fh  <= n_fh;
        end
    end

    assign o_col = r_col;

    `BM3_ASSERT_NXT(a_pos_restart, i_clk, i_rst_n, i_accept && o_item.take && o_item.last, r_col == '0 && r_row == '0)
    `BM3_ASSERT_IMP(a_pos_col_range, i_clk, i_rst_n, 1'b1, FWW'(r_col) < r_fw)
    `BM3_ASSERT_IMP(a_pos_row_range, i_clk, i_rst_n, 1'b1, r_row <= RW'(r_fh) + RW'(1))

endmodule

// File: sv/binary_morph_3x3_neighbour.sv
// ----------------------------------------------------------------------------
// binary_morph_3x3_neighbour
// Streaming binary dilation / erosion over a 3x3 neighborhood.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and gives one result word per clock once the
// window is primed, unless o_res stalls. A word enters the window stage
// together with its line store read at the accepting edge, and its judged
// result enters the output register when it is free. The rate is set
// by the line store, which does one read and one write of a column per cycle,
// and by the three-cell window chain that shifts once per word. A result for a
// center pixel appears one line plus one pixel after that pixel enters, and
// padding words after the frame drain the rest; the word marked last_pixel
// ends the frame. The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "binary_morph_3x3_neighbour_macros.svh"

module binary_morph_3x3_neighbour import bm3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bm3_in_if.sink            i_pix,
    bm3_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic               r_mode;
    logic [MASK_W-1:0]  r_mask;
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    t_item              w_item;
    logic [CW-1:0]      w_col;
    logic               w_acc, w_in_rdy, w_s1_adv, w_out_free, w_load, w_clear;

    logic               r_s1_valid;
    t_item              r_s1;
    logic [CW-1:0]      r_s1_col;

    logic [1:0]         w_rd;
    logic [COL_H-1:0]   w_link [0:COL_H];
    logic [COL_H-1:0]   w_sel  [0:COL_H-1];
    logic [COL_H-1:0]   w_hit;
    logic               w_any;

    logic               r_ovalid;
    logic [PIX_W-1:0]   r_opix;
    logic               r_olast;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_mask  <= RST_MASK;
            r_img_w <= RST_IMG_W;
            r_img_h <= RST_IMG_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_MASK:  r_mask  <= i_cfg_data[MASK_W-1:0];
                REG_IMG_W: r_img_w <= i_cfg_data[IMG_W_W-1:0];
                REG_IMG_H: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign w_out_free  = !r_ovalid || o_res.ready;
    assign w_s1_adv    = r_s1_valid && (!r_s1.emit || w_out_free);
    assign w_in_rdy    = !r_s1_valid || w_s1_adv;
    assign i_pix.ready = w_in_rdy;
    assign w_acc       = i_pix.valid && w_in_rdy;
    assign w_load      = w_s1_adv && r_s1.emit;
    assign w_clear     = w_load && r_s1.last;

    bm3_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_acc),
        .i_pixel  (i_pix.pixel_in),
        .i_pad    (i_pix.is_padding),
        .i_img_w  (r_img_w),
        .i_img_h  (r_img_h),
        .o_col    (w_col),
        .o_item   (w_item)
    );

    bm3_line #(
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc && w_item.take),
        .i_rd_addr (w_col),
        .i_wr_en   (w_s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_link[COL_H][2:1]),
        .o_rd_data (w_rd)
    );

    // window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= w_item.take;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1     <= w_item;
            r_s1_col <= w_col;
        end
    end

    // bit 0 top, bit 1 middle, bit 2 bottom
    assign w_link[COL_H] = {r_s1.set_bit, w_rd};

    always_comb begin
        w_sel[0] = {r_mask[5], r_mask[3], r_mask[0]}
                 & {r_s1.rowv2, 1'b1, r_s1.rowv0} & {COL_H{r_s1.colv0}};
        w_sel[1] = {r_mask[6], 1'b0, r_mask[1]}
                 & {r_s1.rowv2, 1'b1, r_s1.rowv0};
        w_sel[2] = {r_mask[7], r_mask[4], r_mask[2]}
                 & {r_s1.rowv2, 1'b1, r_s1.rowv0} & {COL_H{r_s1.colv2}};
    end

    for (genvar k = 0; k < COL_H; k++) begin : g_cell
        bm3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_s1_adv),
            .i_clear (w_clear),
            .i_col   (w_link[k+1]),
            .i_sel   (w_sel[k]),
            .i_mode  (r_mode),
            .o_col   (w_link[k]),
            .o_hit   (w_hit[k])
        );
    end

    assign w_any = |w_hit;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opix  <= (w_any ^ r_mode) ? PIX_ON : '0;
            r_olast <= r_s1.last;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.pixel_out  = r_opix;
    assign o_res.last_pixel = r_olast;

    `BM3_ASSERT_IMP(a_top_pix_level, i_clk, i_rst_n, r_ovalid, r_opix == '0 || r_opix == PIX_ON)
    `BM3_ASSERT_NXT(a_top_win_clear, i_clk, i_rst_n, w_clear, w_link[0] == '0 && w_link[1] == '0 && w_link[2] == '0)
    `BM3_ASSERT_IMP(a_top_stall_full, i_clk, i_rst_n, !w_in_rdy, r_s1_valid && r_ovalid)

endmodule
